// ===== rtl/utf8d_pkg.sv =====
// shared types and constants for the utf-8 stream decoder
package utf8d_pkg;

	localparam int CP_W = 21;
	localparam int LEN_W = 3;

	localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
	localparam logic [CP_W-1:0] SURR_LEAD_BITS = 21'h00000D;

	localparam logic [LEN_W-1:0] LEN_IDLE = 3'd0;
	localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
	localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
	localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
	localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

	typedef enum logic [2:0] {
		CLS_ASCII,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_INVALID
	} byte_class_t;

	typedef struct packed {
		byte_class_t cls;
		logic [6:0] lead_bits;
		logic [5:0] cont_bits;
		logic surr_range;
		logic eos;
	} byte_info_t;

endpackage

// ===== rtl/utf8d_front.sv =====
// front end: takes bytes and classifies them for the queue
module utf8d_front
	import utf8d_pkg::*;
(
	input logic [7:0] data_byte,
	input logic end_of_string,
	input logic in_valid,
	output logic in_ready,
	input logic q_full,
	output logic q_push,
	output byte_info_t q_info
);

	assign in_ready = !q_full;
	assign q_push = in_valid && !q_full;

	always_comb begin
		q_info.eos = end_of_string;
		q_info.cont_bits = data_byte[5:0];
		q_info.surr_range = (data_byte >= 8'hA0) && (data_byte <= 8'hBF);
		case (data_byte) inside
			[8'h00:8'h7F]: begin
				q_info.cls = CLS_ASCII;
				q_info.lead_bits = data_byte[6:0];
			end
			[8'hC0:8'hDF]: begin
				q_info.cls = CLS_LEAD2;
				q_info.lead_bits = {2'b00, data_byte[4:0]};
			end
			[8'hE0:8'hEF]: begin
				q_info.cls = CLS_LEAD3;
				q_info.lead_bits = {3'b000, data_byte[3:0]};
			end
			[8'hF0:8'hF7]: begin
				q_info.cls = CLS_LEAD4;
				q_info.lead_bits = {4'b0000, data_byte[2:0]};
			end
			default: begin
				q_info.cls = CLS_INVALID;
				q_info.lead_bits = 7'd0;
			end
		endcase
	end

endmodule

// ===== rtl/utf8d_fifo.sv =====
// short queue of classified bytes between front and back
module utf8d_fifo
	import utf8d_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input byte_info_t push_info,
	output logic full,
	input logic pop,
	output logic not_empty,
	output byte_info_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	byte_info_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/utf8d_back.sv =====
// back end: sequence state, code point assembly and output register
module utf8d_back
	import utf8d_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic q_not_empty,
	input byte_info_t q_head,
	output logic q_pop,
	output logic out_valid,
	input logic out_ready,
	output logic [CP_W-1:0] code_point,
	output logic [LEN_W-1:0] bytes_used,
	output logic replaced,
	output logic last
);

	logic [LEN_W-1:0] exp_len_q;
	logic [LEN_W-1:0] seen_q;
	logic [CP_W-1:0] acc_q;
	logic out_valid_q;
	logic [CP_W-1:0] cp_q;
	logic [LEN_W-1:0] used_q;
	logic repl_q;
	logic last_q;

	logic emit;
	logic [CP_W-1:0] res_cp;
	logic [LEN_W-1:0] res_used;
	logic res_repl;
	logic res_last;
	logic [LEN_W-1:0] exp_len_d;
	logic [LEN_W-1:0] seen_d;
	logic [CP_W-1:0] acc_d;
	logic [CP_W-1:0] acc_shift;
	logic [LEN_W-1:0] seen_inc;

	assign q_pop = q_not_empty && (!out_valid_q || out_ready);
	assign acc_shift = {acc_q[CP_W-7:0], q_head.cont_bits};
	assign seen_inc = seen_q + 1'b1;

	always_comb begin
		emit = 1'b0;
		res_cp = REPL_CP;
		res_used = LEN_1;
		res_repl = 1'b1;
		res_last = q_head.eos;
		exp_len_d = LEN_IDLE;
		seen_d = '0;
		acc_d = '0;
		if (exp_len_q == LEN_IDLE) begin
			case (q_head.cls)
				CLS_ASCII: begin
					emit = 1'b1;
					res_cp = {14'd0, q_head.lead_bits};
					res_repl = 1'b0;
				end
				CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
					if (q_head.eos) begin
						emit = 1'b1;
					end else begin
						exp_len_d = (q_head.cls == CLS_LEAD2) ? LEN_2 :
							(q_head.cls == CLS_LEAD3) ? LEN_3 : LEN_4;
						seen_d = LEN_1;
						acc_d = {14'd0, q_head.lead_bits};
					end
				end
				default: begin
					emit = 1'b1;
				end
			endcase
		end else if (exp_len_q == LEN_3 && seen_q == LEN_1 && acc_q == SURR_LEAD_BITS
			&& q_head.surr_range) begin
			emit = 1'b1;
			res_used = LEN_2;
		end else if (seen_inc >= exp_len_q) begin
			emit = 1'b1;
			res_cp = acc_shift;
			res_used = exp_len_q;
			res_repl = 1'b0;
		end else if (q_head.eos) begin
			emit = 1'b1;
			res_used = seen_inc;
		end else begin
			exp_len_d = exp_len_q;
			seen_d = seen_inc;
			acc_d = acc_shift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= LEN_IDLE;
			seen_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				exp_len_q <= exp_len_d;
				seen_q <= seen_d;
				acc_q <= acc_d;
			end
			if (q_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			cp_q <= res_cp;
			used_q <= res_used;
			repl_q <= res_repl;
			last_q <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign code_point = cp_q;
	assign bytes_used = used_q;
	assign replaced = repl_q;
	assign last = last_q;

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// top level of the utf-8 stream decoder
// Decodes a UTF-8 byte stream at one byte per clock sustained while out_ready is held
// high. An accepted byte is classified and placed in a QUEUE_DEPTH-entry queue; the
// back end takes one byte per cycle from the queue, assembles the code point and
// loads the output register, so a result passes through a queue entry and then the
// output register. The back end advances whenever the output register is empty or
// being taken, so the input keeps flowing while a result waits, until the queue fills.
module utf8_stream_decoder
	import utf8d_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic end_of_string,
	output logic out_valid,
	input logic out_ready,
	output logic [20:0] code_point,
	output logic [2:0] bytes_used,
	output logic replaced,
	output logic last
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_not_empty;
	byte_info_t q_in;
	byte_info_t q_head;

	utf8d_front u_front (
		.data_byte(data_byte),
		.end_of_string(end_of_string),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.q_full(q_full),
		.q_push(q_push),
		.q_info(q_in)
	);

	utf8d_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_info(q_in),
		.full(q_full),
		.pop(q_pop),
		.not_empty(q_not_empty),
		.head(q_head)
	);

	utf8d_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_not_empty(q_not_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_point(code_point),
		.bytes_used(bytes_used),
		.replaced(replaced),
		.last(last)
	);

endmodule
